@@ src/bayer_bilinear_demosaic_color_macros.svh @@
// Assertion macros for the Bayer demosaic block.
`ifndef BAYER_BILINEAR_DEMOSAIC_COLOR_MACROS_SVH
`define BAYER_BILINEAR_DEMOSAIC_COLOR_MACROS_SVH

// Same-cycle implication, reset disables the check.
`define BBD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset disables the check.
`define BBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/bbd_pkg.sv @@
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared types, register indexes and the CFA color table for the demosaic.
// ----------------------------------------------------------------------------
`default_nettype none

package bbd_pkg;

    localparam logic [2:0] REG_FRAME_SIZE  = 3'd0;
    localparam logic [2:0] REG_CFA_PHASE   = 3'd1;
    localparam logic [2:0] REG_BLACK_LEVEL = 3'd2;
    localparam logic [2:0] REG_RANGE_RECIP = 3'd3;
    localparam logic [2:0] REG_WB_GAINS    = 3'd4;
    localparam logic [2:0] REG_MATRIX_R    = 3'd5;
    localparam logic [2:0] REG_MATRIX_G    = 3'd6;
    localparam logic [2:0] REG_MATRIX_B    = 3'd7;

    localparam logic [1:0] COL_RED   = 2'd0;
    localparam logic [1:0] COL_GREEN = 2'd1;
    localparam logic [1:0] COL_BLUE  = 2'd2;

    // index: {phase, y parity, x parity}
    localparam logic [1:0] CFA_TAB [16] = '{
        COL_RED,   COL_GREEN, COL_GREEN, COL_BLUE,
        COL_GREEN, COL_RED,   COL_BLUE,  COL_GREEN,
        COL_GREEN, COL_BLUE,  COL_RED,   COL_GREEN,
        COL_BLUE,  COL_GREEN, COL_GREEN, COL_RED
    };

    localparam int BAL_BITS = 20;
    localparam int COR_BITS = 21;

    typedef struct packed {
        logic [31:0] frame_size;
        logic [1:0]  cfa_phase;
        logic [15:0] black_level;
        logic [31:0] range_recip;
        logic [47:0] wb_gains;
        logic [47:0] matrix_r;
        logic [47:0] matrix_g;
        logic [47:0] matrix_b;
    } cfg_t;

    typedef struct packed {
        logic       accept;
        logic       norm;
        logic       win;
        logic       rgb;
        logic       bal;
        logic       mat;
        logic [1:0] emit;
        logic [1:0] row;
        logic [1:0] k;
    } cmd_t;

    typedef struct packed {
        logic [3:0] emit_mask;
    } status_t;

endpackage

`default_nettype wire

@@ src/bbd_regs.sv @@
// ----------------------------------------------------------------------------
// bbd_regs
// Configuration register file, written through the index/data channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bbd_regs
    import bbd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_size  <= 32'd0;
            cfg_reg.cfa_phase   <= 2'd0;
            cfg_reg.black_level <= 16'd0;
            cfg_reg.range_recip <= 32'd65536;
            cfg_reg.wb_gains    <= 48'd17592454483968;
            cfg_reg.matrix_r    <= 48'd4096;
            cfg_reg.matrix_g    <= 48'd268435456;
            cfg_reg.matrix_b    <= 48'd17592186044416;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRAME_SIZE:  cfg_reg.frame_size  <= cfg_data[31:0];
                REG_CFA_PHASE:   cfg_reg.cfa_phase   <= cfg_data[1:0];
                REG_BLACK_LEVEL: cfg_reg.black_level <= cfg_data[15:0];
                REG_RANGE_RECIP: cfg_reg.range_recip <= cfg_data[31:0];
                REG_WB_GAINS:    cfg_reg.wb_gains    <= cfg_data;
                REG_MATRIX_R:    cfg_reg.matrix_r    <= cfg_data;
                REG_MATRIX_G:    cfg_reg.matrix_g    <= cfg_data;
                REG_MATRIX_B:    cfg_reg.matrix_b    <= cfg_data;
                default:         cfg_reg.frame_size  <= cfg_reg.frame_size;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/bbd_dp.sv @@
// ----------------------------------------------------------------------------
// bbd_dp
// Datapath: normalize, line memory, 3x3 window, interpolation, balance, matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module bbd_dp
    import bbd_pkg::*;
#(
    parameter int MAX_WIDTH   = 4096,
    parameter int SAMPLE_BITS = 16
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cfg_t          cfg,
    input  wire cmd_t          cmd,
    output status_t            status,
    input  wire logic [15:0]   raw_sample,
    input  wire logic          frame_start,
    output logic [175:0]       out_data,
    output logic               out_last
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [31:0] line_mem [MAX_WIDTH];

    logic [15:0] raw_reg;
    logic        ok_reg;
    logic [15:0] col_reg, row_reg, col_cnt_reg, row_cnt_reg;
    logic [47:0] prod_reg;
    logic [31:0] rd_reg;
    logic [15:0] win_reg [9];
    logic [15:0] rgb_reg [3];
    logic [BAL_BITS-1:0] bal_reg [3];
    logic [COR_BITS-1:0] cor_reg [3];
    logic signed [38:0]  acc_reg;
    logic        last_reg;

    logic [15:0] w, h;
    logic        ok, restart;
    logic [15:0] col_eff, row_eff;
    logic [15:0] r_smp, d;
    logic [48:0] pr;
    logic [15:0] s;
    logic [15:0] a_old, b_old;
    logic [15:0] col_inc, row_inc;

    assign w = cfg.frame_size[15:0];
    assign h = cfg.frame_size[31:16];
    assign ok = (w != 16'd0) && (h != 16'd0) && ({1'b0, w} <= 17'(MAX_WIDTH));
    assign restart = frame_start || (col_cnt_reg >= w) || (row_cnt_reg >= h);
    assign col_eff = restart ? 16'd0 : col_cnt_reg;
    assign row_eff = restart ? 16'd0 : row_cnt_reg;

    assign r_smp = 16'(raw_reg[SAMPLE_BITS-1:0]);
    assign d     = (r_smp > cfg.black_level) ? (r_smp - cfg.black_level) : 16'd0;
    assign pr    = ({1'b0, prod_reg} + 49'd2) >> 2;
    assign s     = (pr > 49'd65535) ? 16'hFFFF : pr[15:0];
    assign a_old = rd_reg[15:0];
    assign b_old = rd_reg[31:16];
    assign col_inc = col_reg + 16'd1;
    assign row_inc = row_reg + 16'd1;

    always_comb
    begin
        status.emit_mask[0] = ok_reg && (row_reg >= 16'd1) && (col_reg >= 16'd1);
        status.emit_mask[1] = ok_reg && (row_reg >= 16'd1) && (col_reg == w - 16'd1);
        status.emit_mask[2] = ok_reg && (row_reg == h - 16'd1) && (col_reg >= 16'd1);
        status.emit_mask[3] = ok_reg && (row_reg == h - 16'd1) && (col_reg == w - 16'd1);
    end

    // line memory word: previous row in the low half, the row before it high
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            rd_reg <= line_mem[col_eff[AW-1:0]];
        if (cmd.win && ok_reg)
            line_mem[col_reg[AW-1:0]] <= {a_old, s};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg      <= 1'b0;
            col_reg     <= 16'd0;
            row_reg     <= 16'd0;
            col_cnt_reg <= 16'd0;
            row_cnt_reg <= 16'd0;
            for (int i = 0; i < 9; i++)
                win_reg[i] <= 16'd0;
        end
        else
        begin
            if (cmd.accept)
            begin
                ok_reg  <= ok;
                col_reg <= col_eff;
                row_reg <= row_eff;
            end
            if (cmd.win && ok_reg)
            begin
                if (col_inc >= w)
                begin
                    col_cnt_reg <= 16'd0;
                    row_cnt_reg <= (row_inc >= h) ? 16'd0 : row_inc;
                end
                else
                begin
                    col_cnt_reg <= col_inc;
                    row_cnt_reg <= row_reg;
                end
                if (col_reg == 16'd0)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        win_reg[c*3]   <= b_old;
                        win_reg[c*3+1] <= a_old;
                        win_reg[c*3+2] <= s;
                    end
                end
                else
                begin
                    for (int i = 0; i < 6; i++)
                        win_reg[i] <= win_reg[i+3];
                    win_reg[6] <= b_old;
                    win_reg[7] <= a_old;
                    win_reg[8] <= s;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            raw_reg <= raw_sample;
        if (cmd.norm)
            prod_reg <= 48'(d) * 48'(cfg.range_recip);
    end

    // interpolation of one pixel from the window
    logic        right, lower;
    logic [15:0] px, py;
    logic [15:0] p [3][3];
    logic [1:0]  ccol, hc;
    logic [16:0] h2, v2;
    logic [17:0] s4a, s4d;
    logic [15:0] rgb_n [3];
    logic [15:0] cb, ca, cs;

    assign right = cmd.emit[0];
    assign lower = cmd.emit[1];
    assign px = right ? col_reg : (col_reg - 16'd1);
    assign py = lower ? row_reg : (row_reg - 16'd1);

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (right)
            begin
                cb = win_reg[(c == 0) ? 3 : 6];
                ca = win_reg[(c == 0) ? 4 : 7];
                cs = win_reg[(c == 0) ? 5 : 8];
            end
            else
            begin
                cb = win_reg[c*3];
                ca = win_reg[c*3+1];
                cs = win_reg[c*3+2];
            end
            if (!lower)
            begin
                p[0][c] = (row_reg >= 16'd2) ? cb : ca;
                p[1][c] = ca;
                p[2][c] = cs;
            end
            else
            begin
                p[0][c] = (row_reg >= 16'd1) ? ca : cs;
                p[1][c] = cs;
                p[2][c] = cs;
            end
        end
    end

    assign ccol = CFA_TAB[{cfg.cfa_phase, py[0], px[0]}];
    assign hc   = CFA_TAB[{cfg.cfa_phase, py[0], ~px[0]}];
    assign h2   = (17'(p[1][0]) + 17'(p[1][2]) + 17'd1) >> 1;
    assign v2   = (17'(p[0][1]) + 17'(p[2][1]) + 17'd1) >> 1;
    assign s4a  = (18'(p[1][0]) + 18'(p[1][2]) + 18'(p[0][1]) + 18'(p[2][1]) + 18'd2) >> 2;
    assign s4d  = (18'(p[0][0]) + 18'(p[0][2]) + 18'(p[2][0]) + 18'(p[2][2]) + 18'd2) >> 2;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            rgb_n[k] = 16'd0;
        rgb_n[ccol] = p[1][1];
        if (ccol == COL_GREEN)
        begin
            rgb_n[hc]             = h2[15:0];
            rgb_n[2'(2'd2 - hc)]  = v2[15:0];
        end
        else
        begin
            rgb_n[COL_GREEN]       = s4a[15:0];
            rgb_n[2'(2'd2 - ccol)] = s4d[15:0];
        end
    end

    // balance and matrix, one product a cycle
    logic [15:0] gain;
    logic [31:0] bprod;
    logic [20:0] bv;
    logic [47:0] mrow;
    logic signed [15:0] coef;
    logic signed [36:0] term;
    logic signed [38:0] msum;
    logic signed [26:0] q;
    logic [COR_BITS-1:0] qsat;

    assign gain  = cfg.wb_gains[{cmd.k, 4'd0} +: 16];
    assign bprod = 32'(rgb_reg[cmd.k]) * 32'(gain);
    assign bv    = 21'((33'(bprod) + 33'd2048) >> 12);

    always_comb
    begin
        case (cmd.row)
            2'd0:    mrow = cfg.matrix_r;
            2'd1:    mrow = cfg.matrix_g;
            default: mrow = cfg.matrix_b;
        endcase
    end

    assign coef = signed'(mrow[{cmd.k, 4'd0} +: 16]);
    assign term = 37'(coef) * 37'(signed'({1'b0, bal_reg[cmd.k]}));
    assign msum = ((cmd.k == 2'd0) ? 39'sd0 : acc_reg) + 39'(term);
    assign q    = 27'((msum + 39'sd2048) >>> 12);

    always_comb
    begin
        if (q > 27'sd1048575)
            qsat = 21'h0FFFFF;
        else if (q < -27'sd1048576)
            qsat = 21'h100000;
        else
            qsat = q[COR_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rgb)
        begin
            for (int k = 0; k < 3; k++)
                rgb_reg[k] <= rgb_n[k];
            last_reg <= (px == w - 16'd1) && (py == h - 16'd1);
        end
        if (cmd.bal)
            bal_reg[cmd.k] <= (bv > 21'd1048575) ? 20'hFFFFF : bv[19:0];
        if (cmd.mat)
        begin
            acc_reg <= msum;
            if (cmd.k == 2'd2)
                cor_reg[cmd.row] <= qsat;
        end
    end

    assign out_data = {5'd0, cor_reg[2], cor_reg[1], cor_reg[0],
                       bal_reg[2], bal_reg[1], bal_reg[0],
                       rgb_reg[2], rgb_reg[1], rgb_reg[0]};
    assign out_last = last_reg;

endmodule

`default_nettype wire

@@ src/bbd_ctrl.sv @@
// ----------------------------------------------------------------------------
// bbd_ctrl
// Sequencer: takes one word, runs the window update, then each pending pixel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bayer_bilinear_demosaic_color_macros.svh"

module bbd_ctrl
    import bbd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_NORM = 8'b0000_0010,
        ST_WIN  = 8'b0000_0100,
        ST_SEL  = 8'b0000_1000,
        ST_RGB  = 8'b0001_0000,
        ST_BAL  = 8'b0010_0000,
        ST_MAT  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  mask_reg, mask_next;
    logic [1:0]  e_reg, e_next;
    logic [1:0]  r_reg, r_next;
    logic [1:0]  k_reg, k_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    always_comb
    begin
        state_next = state_reg;
        mask_next  = mask_reg;
        e_next     = e_reg;
        r_next     = r_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_NORM;
            ST_NORM:
                state_next = ST_WIN;
            ST_WIN:
            begin
                mask_next  = status.emit_mask;
                e_next     = 2'd0;
                state_next = ST_SEL;
            end
            ST_SEL:
                if (mask_reg[e_reg])
                begin
                    state_next = ST_RGB;
                end
                else if (e_reg == 2'd3)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    e_next = e_reg + 2'd1;
                end
            ST_RGB:
            begin
                k_next     = 2'd0;
                state_next = ST_BAL;
            end
            ST_BAL:
                if (k_reg == 2'd2)
                begin
                    k_next     = 2'd0;
                    r_next     = 2'd0;
                    state_next = ST_MAT;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            ST_MAT:
                if (k_reg == 2'd2)
                begin
                    k_next = 2'd0;
                    if (r_reg == 2'd2)
                        state_next = ST_OUT;
                    else
                        r_next = r_reg + 2'd1;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            ST_OUT:
                if (out_ready)
                begin
                    if (e_reg == 2'd3)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        e_next     = e_reg + 2'd1;
                        state_next = ST_SEL;
                    end
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mask_reg  <= 4'd0;
            e_reg     <= 2'd0;
            r_reg     <= 2'd0;
            k_reg     <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            mask_reg  <= mask_next;
            e_reg     <= e_next;
            r_reg     <= r_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        cmd.accept = (state_reg == ST_IDLE) && in_valid;
        cmd.norm   = (state_reg == ST_NORM);
        cmd.win    = (state_reg == ST_WIN);
        cmd.rgb    = (state_reg == ST_RGB);
        cmd.bal    = (state_reg == ST_BAL);
        cmd.mat    = (state_reg == ST_MAT);
        cmd.emit   = e_reg;
        cmd.row    = r_reg;
        cmd.k      = k_reg;
    end

    `BBD_ASSERT_NOW(a_no_overlap, in_ready, !out_valid, "input taken while a pixel is pending")
    `BBD_ASSERT_NOW(a_out_pending, out_valid, mask_reg[e_reg], "pixel shown that was not scheduled")
    `BBD_ASSERT_NEXT(a_accept_norm, in_valid && in_ready, state_reg == ST_NORM, "accept did not start normalize")

endmodule

`default_nettype wire

@@ src/bayer_bilinear_demosaic_color.sv @@
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_color
// Bilinear Bayer demosaic with white balance and color matrix, fixed point.
// ----------------------------------------------------------------------------
//  Channel   Signals                            Word
//  s_        tvalid/tready/tdata/tuser          raw sample, frame start
//  m_        tvalid/tready/tdata/tlast          interp, balanced, matrix RGB
//  cfg_      valid/ready/index/data             register index, value
//
//  One word at a time: normalize and update the window, then scan each of
//  the four pixel slots and interpolate, balance and matrix each pixel given.
//  The pixel cost is set by the balance and matrix multipliers, one product
//  a cycle. Output stalls hold the sequencer in place.
//  Reset clears counters and window; the line memory needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module bayer_bilinear_demosaic_color
    import bbd_pkg::*;
#(
    parameter int MAX_WIDTH   = 4096,
    parameter int SAMPLE_BITS = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [15:0]  s_tdata,   // raw_sample
    input  wire logic         s_tuser,   // frame_start
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // interp_red, interp_green, interp_blue, bal_red, bal_green, bal_blue,
    // cor_red, cor_green, cor_blue, zero pad
    output logic [175:0]      m_tdata,
    output logic              m_tlast,   // frame_last
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [47:0]  cfg_data
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    bbd_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    bbd_dp #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .status      (status),
        .raw_sample  (s_tdata),
        .frame_start (s_tuser),
        .out_data    (m_tdata),
        .out_last    (m_tlast)
    );

endmodule

`default_nettype wire
